>>> sv/acp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acp_pkg: shared types and constants of the coordinate pair parser
// Parse phases, the per-line parse state and the character codes.
// ----------------------------------------------------------------------------
package acp_pkg;

  // Character codes the parser reacts to.
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChMinus   = 8'h2D;

  // Magnitude cap: one more than the largest positive value.
  localparam logic [16:0] MagCap   = 17'd32768;
  localparam logic [16:0] MagPosMax = 17'd32767;

  // Configuration register indexes.
  localparam logic RegDefaultX = 1'b0;
  localparam logic RegDefaultY = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] DefaultXReset = 16'd320;
  localparam logic [15:0] DefaultYReset = 16'd240;

  typedef enum logic [2:0] {
    PH_START,   // expecting first number
    PH_SIGN1,   // first minus seen
    PH_DIG1,    // in first digits
    PH_START2,  // expecting second number
    PH_SIGN2,   // second minus seen
    PH_DIG2,    // in second digits
    PH_DONE,    // second number complete
    PH_FAIL     // matching failed
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic        neg;    // sign; in PH_FAIL set when the first number failed
    logic [16:0] acc;    // magnitude being read
    logic [15:0] first;  // first number once complete
  } line_state_t;

  typedef struct packed {
    logic is_newline;  // byte ends the line
    logic is_keeper;   // byte is a digit, comma or minus
  } byte_class_t;

  localparam line_state_t LineReset = '{phase: PH_START, neg: 1'b0,
                                        acc: 17'd0, first: 16'd0};

endpackage
`default_nettype wire

>>> sv/acp_parse_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acp_parse_step: one byte step of the coordinate pair parser
// Classifies a byte, advances the line state and forms the result on newline.
// ----------------------------------------------------------------------------
module acp_parse_step (
  input  wire logic [7:0]          byte_i,
  input  wire logic                room_i,    // line still has room for a kept byte
  input  wire acp_pkg::line_state_t state_i,
  input  wire logic [15:0]         def_x_i,
  input  wire logic [15:0]         def_y_i,
  output acp_pkg::byte_class_t     class_o,
  output acp_pkg::line_state_t     state_o,
  output logic [15:0]              coord_x_o,
  output logic [15:0]              coord_y_o
);
  import acp_pkg::*;

  logic        dig;
  logic [3:0]  digit;
  logic        keep;
  logic [19:0] acc_x10;
  logic [16:0] acc_next;
  logic [15:0] cur_val;
  phase_e      phase_d;

  // Saturated signed value of the number being read.
  function automatic logic [15:0] sat_value(input logic neg, input logic [16:0] acc);
    logic [16:0] m;
    logic [16:0] neg_m;
    m     = 17'd0;
    neg_m = 17'd0;
    if (neg) begin
      m     = (acc > MagCap) ? MagCap : acc;
      neg_m = 17'h10000 - m;
      return neg_m[15:0];
    end
    m = (acc > MagPosMax) ? MagPosMax : acc;
    return m[15:0];
  endfunction

  assign dig   = byte_i inside {[ChZero:ChNine]};
  assign digit = byte_i[3:0];
  assign class_o.is_newline = (byte_i == ChNewline);
  assign class_o.is_keeper  = dig || (byte_i == ChComma) || (byte_i == ChMinus);
  assign keep  = class_o.is_keeper && room_i && !class_o.is_newline;

  assign acc_x10  = ({3'b000, state_i.acc} << 3) + ({3'b000, state_i.acc} << 1)
                  + {16'd0, digit};
  assign acc_next = (acc_x10 > {3'b000, MagCap}) ? MagCap : acc_x10[16:0];
  assign cur_val  = sat_value(state_i.neg, state_i.acc);

  // Next phase.
  always_comb begin
    phase_d = state_i.phase;
    case (state_i.phase)
      PH_START: begin
        if (dig)                    phase_d = PH_DIG1;
        else if (byte_i == ChMinus) phase_d = PH_SIGN1;
        else                        phase_d = PH_FAIL;
      end
      PH_SIGN1: phase_d = dig ? PH_DIG1 : PH_FAIL;
      PH_DIG1: begin
        if (dig)                    phase_d = PH_DIG1;
        else if (byte_i == ChComma) phase_d = PH_START2;
        else                        phase_d = PH_FAIL;
      end
      PH_START2: begin
        if (dig)                    phase_d = PH_DIG2;
        else if (byte_i == ChMinus) phase_d = PH_SIGN2;
        else                        phase_d = PH_FAIL;
      end
      PH_SIGN2: phase_d = dig ? PH_DIG2 : PH_FAIL;
      PH_DIG2:  phase_d = dig ? PH_DIG2 : PH_DONE;
      default:  phase_d = state_i.phase;
    endcase
  end

  // Next state data and the result of a newline.
  always_comb begin
    state_o   = state_i;
    coord_x_o = def_x_i;
    coord_y_o = def_y_i;
    case (state_i.phase)
      PH_DIG1: begin
        coord_x_o = cur_val;
      end
      PH_START2, PH_SIGN2: begin
        coord_x_o = state_i.first;
      end
      PH_DIG2, PH_DONE: begin
        coord_x_o = state_i.first;
        coord_y_o = cur_val;
      end
      PH_FAIL: begin
        if (!state_i.neg) coord_x_o = state_i.first;
      end
      default: begin
        coord_x_o = def_x_i;
      end
    endcase

    if (class_o.is_newline) begin
      state_o = LineReset;
    end else if (keep) begin
      state_o.phase = phase_d;
      case (state_i.phase)
        PH_START, PH_START2: begin
          if (dig)                    state_o.acc = {13'd0, digit};
          else if (byte_i == ChMinus) state_o.neg = 1'b1;
          else begin
            state_o.neg = (state_i.phase == PH_START);
            state_o.acc = 17'd0;
          end
        end
        PH_SIGN1, PH_SIGN2: begin
          if (dig) state_o.acc = {13'd0, digit};
          else begin
            state_o.neg = (state_i.phase == PH_SIGN1);
            state_o.acc = 17'd0;
          end
        end
        PH_DIG1: begin
          if (dig) state_o.acc = acc_next;
          else begin
            state_o.first = cur_val;
            state_o.acc   = 17'd0;
            state_o.neg   = 1'b0;
          end
        end
        PH_DIG2: begin
          if (dig) state_o.acc = acc_next;
        end
        default: begin
          state_o = state_i;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/ascii_coordinate_pair_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_coordinate_pair_parser: ASCII "x,y" line parser
// Parses received bytes into a signed 16-bit coordinate pair per line.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload (low bits first)          Transfer when
//   s_axis    in         tdata[7:0] rx_byte                tvalid && tready
//   m_axis    out        tdata[15:0] coord_x,              tvalid && tready
//                        tdata[31:16] coord_y
//   cfg       in         idx 0 default_x, idx 1 default_y  cfg_we_i
//
// Each byte is captured in an input register; from there the parse step
// updates the line state and, for a newline, loads the result register.
// One byte is accepted every cycle while results drain; the result register
// is the only point of backpressure. A stalled result holds the input
// register, and the input register stops accepting once it is full.
// Reset clears the line state and both handshakes and loads the defaults
// (320, 240); no clearing pass is needed.
//
module ascii_coordinate_pair_parser #(
  parameter int LINE_BYTES = 32   // line length limit; LINE_BYTES-1 bytes kept
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Byte stream in.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Coordinate pairs out.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] coord_x, [31:16] coord_y
  // Configuration writes.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);
  import acp_pkg::*;

  localparam int CntW = $clog2(LINE_BYTES);
  localparam logic [CntW-1:0] KeptMax = CntW'(LINE_BYTES - 1);

  // Input register.
  logic             in_vld_q, in_vld_d;
  logic [7:0]       in_byte_q;

  // Line state.
  line_state_t      line_q, line_d;
  logic [CntW-1:0]  kept_q, kept_d;

  // Configuration registers.
  logic [15:0]      def_x_q, def_y_q;

  // Result register.
  logic             out_vld_q, out_vld_d;
  logic [31:0]      out_data_q;

  logic             adv;
  logic             proc;
  logic             room;
  byte_class_t      cls;
  logic [15:0]      coord_x, coord_y;

  // The step advances whenever the result register can take a new value.
  assign adv           = !out_vld_q || m_axis_tready;
  assign proc          = in_vld_q && adv;
  assign s_axis_tready = !in_vld_q || adv;
  assign room          = (kept_q < KeptMax);

  acp_parse_step u_step (
    .byte_i    (in_byte_q),
    .room_i    (room),
    .state_i   (line_q),
    .def_x_i   (def_x_q),
    .def_y_i   (def_y_q),
    .class_o   (cls),
    .state_o   (line_d),
    .coord_x_o (coord_x),
    .coord_y_o (coord_y)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tready) in_vld_d = s_axis_tvalid;
  end

  // Kept bytes count toward the line limit; a newline starts a new line.
  always_comb begin
    kept_d = kept_q;
    if (cls.is_newline)                  kept_d = '0;
    else if (cls.is_keeper && room)      kept_d = kept_q + CntW'(1);
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (proc && cls.is_newline) out_vld_d = 1'b1;
    else if (m_axis_tready)     out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      line_q    <= LineReset;
      kept_q    <= '0;
      def_x_q   <= DefaultXReset;
      def_y_q   <= DefaultYReset;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (proc) begin
        line_q <= line_d;
        kept_q <= kept_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDefaultX: def_x_q <= cfg_wdata_i;
          RegDefaultY: def_y_q <= cfg_wdata_i;
          default:     def_x_q <= def_x_q;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_byte_q <= s_axis_tdata;
    if (proc && cls.is_newline)         out_data_q <= {coord_y, coord_x};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

>>> sv/acp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acp_checker: port-level checks of the coordinate pair parser
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module acp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);
  import acp_pkg::*;

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

  // With no result pending, the byte input is never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A fresh result follows an earlier newline transfer on the byte input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && (s_axis_tdata == ChNewline), 2))
    else $error("result without a newline");

endmodule

bind ascii_coordinate_pair_parser acp_checker u_acp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ASCII coordinate pair parser
// Streams text lines into the parser with random gaps and output stalls. A
// scoreboard mirrors the line state and checks every coordinate pair.
// ----------------------------------------------------------------------------
module testbench;
  import acp_pkg::*;

  localparam int LineBytes     = 32;
  localparam int NumPhases     = 12;
  localparam int PhaseBytes    = 100;
  localparam int SettleCycles  = 8;
  localparam int WatchdogLimit = 3000;

  // One result transfer, laid out as it appears on m_axis_tdata.
  typedef struct packed {
    logic [15:0] y;
    logic [15:0] x;
  } coord_pair_t;

  // Mirrors the parser's line state and keeps the pairs it still owes.
  class coord_scoreboard;
    logic [15:0] dflt_x;
    logic [15:0] dflt_y;
    int unsigned kept;
    phase_e      phase;
    bit          neg;
    logic [16:0] mag;
    logic [15:0] first_num;
    coord_pair_t owed[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      dflt_x  = DefaultXReset;
      dflt_y  = DefaultYReset;
      errors  = 0;
      checked = 0;
      clear_line();
    endfunction

    function void clear_line();
      kept      = 0;
      phase     = PH_START;
      neg       = 1'b0;
      mag       = '0;
      first_num = '0;
    endfunction

    function void load_default(logic idx, logic [15:0] value);
      if (idx == RegDefaultX) dflt_x = value;
      else dflt_y = value;
    endfunction

    // Signed pattern of the number being read, clamped to 16 bits.
    function logic [15:0] value_now();
      logic [16:0] m;
      logic [16:0] t;
      m = mag;
      if (neg) begin
        if (m > MagCap) m = MagCap;
        t = 17'h10000 - m;
        return t[15:0];
      end
      if (m > MagPosMax) m = MagPosMax;
      return m[15:0];
    endfunction

    function void add_digit(logic [16:0] d);
      int unsigned v;
      v = mag * 10 + d;
      mag = (v > MagCap) ? MagCap : v[16:0];
    endfunction

    function void fail_at(bit first_failed);
      phase = PH_FAIL;
      neg   = first_failed;
      mag   = '0;
    endfunction

    function void parse_keeper(logic [7:0] c);
      bit          dig;
      logic [16:0] d;
      dig = (c >= ChZero) && (c <= ChNine);
      d   = c - ChZero;
      case (phase)
        PH_START: begin
          if (dig) begin mag = d; phase = PH_DIG1; end
          else if (c == ChMinus) begin neg = 1'b1; phase = PH_SIGN1; end
          else fail_at(1'b1);
        end
        PH_SIGN1: begin
          if (dig) begin mag = d; phase = PH_DIG1; end
          else fail_at(1'b1);
        end
        PH_DIG1: begin
          if (dig) add_digit(d);
          else begin
            first_num = value_now();
            if (c == ChComma) begin
              mag   = '0;
              neg   = 1'b0;
              phase = PH_START2;
            end else begin
              fail_at(1'b0);
            end
          end
        end
        PH_START2: begin
          if (dig) begin mag = d; phase = PH_DIG2; end
          else if (c == ChMinus) begin neg = 1'b1; phase = PH_SIGN2; end
          else fail_at(1'b0);
        end
        PH_SIGN2: begin
          if (dig) begin mag = d; phase = PH_DIG2; end
          else fail_at(1'b0);
        end
        PH_DIG2: begin
          if (dig) add_digit(d);
          else phase = PH_DONE;
        end
        default: ;
      endcase
    endfunction

    // Called for every accepted byte; a newline produces the owed pair.
    function void note_byte(logic [7:0] c);
      coord_pair_t p;
      bit keeper;
      keeper = ((c >= ChZero) && (c <= ChNine)) || c == ChComma || c == ChMinus;
      if (c == ChNewline) begin
        case (phase)
          PH_DIG1: begin p.x = value_now(); p.y = dflt_y; end
          PH_START2, PH_SIGN2: begin p.x = first_num; p.y = dflt_y; end
          PH_DIG2, PH_DONE: begin p.x = first_num; p.y = value_now(); end
          PH_FAIL: begin
            p.x = neg ? dflt_x : first_num;
            p.y = dflt_y;
          end
          default: begin p.x = dflt_x; p.y = dflt_y; end
        endcase
        owed.push_back(p);
        clear_line();
      end else if (keeper && kept < LineBytes - 1) begin
        kept++;
        parse_keeper(c);
      end
    endfunction

    function void check_pair(coord_pair_t got);
      coord_pair_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected pair x=%0d y=%0d", $time,
                 $signed(got.x), $signed(got.y));
        errors++;
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got.x !== want.x) begin
        $display("%0t: coord_x mismatch, expected %0d, got %0d", $time,
                 $signed(want.x), $signed(got.x));
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: coord_y mismatch, expected %0d, got %0d", $time,
                 $signed(want.y), $signed(got.y));
        errors++;
      end
    endfunction

    function int waiting();
      return owed.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  coord_scoreboard board;
  logic [7:0]      line_buf[$];
  bit              src_idle_on;
  bit              sink_idle_on;
  int unsigned     bytes_sent;
  int unsigned     settings_used;

  ascii_coordinate_pair_parser #(.LINE_BYTES(LineBytes)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // The receiver stalls about a fifth of the time while its idling is on.
  always @(negedge clk_i) begin
    m_axis_tready <= !sink_idle_on || ($urandom_range(0, 99) >= 20);
  end

  // Every result transfer is checked against the oldest owed pair.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_pair(m_axis_tdata);
  end

  // The watchdog ends the run once nothing has moved for too long: no byte
  // transfer, no result transfer and no register write.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          cfg_we_i || !rst_ni) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
    $display("testbench: errors");
    $finish;
  end

  // Offers one byte and waits for its transfer. The valid stays high after
  // the transfer so back-to-back bytes leave no gap; an idle cycle lowers it.
  task automatic send_byte(input logic [7:0] c);
    @(negedge clk_i);
    while (src_idle_on && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i]);
  endtask

  // Stops sending and waits until every owed pair has come out, then lets
  // the pipeline settle so bytes that give no result are through as well.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_defaults(input logic [15:0] x, input logic [15:0] y);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegDefaultX;
    cfg_wdata_i <= x;
    board.load_default(RegDefaultX, x);
    @(negedge clk_i);
    cfg_idx_i   <= RegDefaultY;
    cfg_wdata_i <= y;
    board.load_default(RegDefaultY, y);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Any byte the parser drops: neither a keeper nor a newline.
  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ChNewline || c == ChComma || c == ChMinus ||
           (c >= ChZero && c <= ChNine));
    return c;
  endfunction

  function automatic logic [7:0] any_keeper();
    case ($urandom_range(0, 5))
      0: return ChComma;
      1: return ChMinus;
      default: return 8'(ChZero + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic void push_number();
    int n;
    if ($urandom_range(0, 2) == 0) line_buf.push_back(ChMinus);
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 9);
    repeat (n) line_buf.push_back(8'(ChZero + $urandom_range(0, 9)));
  endfunction

  // Builds one line in line_buf. Most lines are well formed pairs with random
  // values; the rest are overlong lines and random keeper soup. Dropped
  // bytes are sprinkled in while the line is sent.
  function automatic void build_line();
    int r;
    line_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 70) begin
      push_number();
      line_buf.push_back(ChComma);
      push_number();
      repeat ($urandom_range(0, 3)) line_buf.push_back(any_keeper());
    end else if (r < 80) begin
      repeat ($urandom_range(20, 45)) line_buf.push_back(any_keeper());
    end else begin
      repeat ($urandom_range(0, 8)) line_buf.push_back(any_keeper());
    end
    line_buf.push_back(ChNewline);
  endfunction

  task automatic send_line(input int upto);
    for (int i = 0; i < upto; i++) begin
      if ($urandom_range(0, 99) < 8) send_byte(noise_byte());
      send_byte(line_buf[i]);
    end
  endtask

  initial begin : stimulus
    int phase_start;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegDefaultX;
    cfg_wdata_i   = '0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    bytes_sent    = 0;
    settings_used = 1;
    board = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines with the reset defaults: an empty line, a leading
    // comma, a lone minus, a minus before a comma, a first number with no
    // comma wrapped in all-zero and all-one dropped bytes, and a negative
    // zero followed by an overlong negative magnitude.
    send_text("\n");
    send_text(",5\n");
    send_text("-\n");
    send_text("-,3\n");
    send_byte(8'hFF);
    send_byte(ChZero + 8'd7);
    send_byte(8'h00);
    send_byte(ChNewline);
    send_text("-0,-99999\n");
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      // Phase 0 keeps the reset defaults; phases 1 to 3 hit the extremes, the rest are random.
      case (p)
        0: ;
        1: write_defaults(16'h8000, 16'h7FFF);
        2: write_defaults(16'h7FFF, 16'h8000);
        3: write_defaults(16'h0000, 16'hFFFF);
        default: write_defaults(16'($urandom_range(0, 16'hFFFF)),
                                16'($urandom_range(0, 16'hFFFF)));
      endcase
      // Phases four to six run with both sides at full rate.
      src_idle_on  = !(p >= 4 && p <= 6);
      sink_idle_on = !(p >= 4 && p <= 6);
      phase_start  = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        build_line();
        send_line(line_buf.size());
      end
      // On odd phases a line is left half sent, so the next defaults are
      // written in the middle of that line and apply to its result.
      if (p % 2 == 1) begin
        build_line();
        send_line($urandom_range(1, line_buf.size() - 1));
      end
      drain();
    end

    // Close any open line and collect its pair.
    send_byte(ChNewline);
    drain();

    $display("run summary: %0d bytes sent, %0d coordinate pairs checked",
             bytes_sent, board.checked);
    $display("run summary: %0d default settings, %0d mismatches",
             settings_used, board.errors);
    if (board.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> files.f
sv/acp_pkg.sv
sv/acp_parse_step.sv
sv/ascii_coordinate_pair_parser.sv
sv/acp_checker.sv
dv/testbench.sv
